// ----- rtl/core/opl_pkg.sv -----
package opl_pkg;

  // List capacity and derived widths
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned POS_W = 8;
  localparam int unsigned CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  // Request operation codes
  typedef enum logic [2:0] {
    FUNC_APPEND = 3'd0,
    FUNC_INSERT = 3'd1,
    FUNC_REMOVE = 3'd2,
    FUNC_READ   = 3'd3,
    FUNC_CLEAR  = 3'd4
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  // Broadcast command to every cell of the list
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] where;
    point_t           pt;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/opl_if.sv -----
interface opl_req_if;
  import opl_pkg::*;

  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [POS_W-1:0]   position;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;

  modport source (output valid, output func, output position, output point_x,
                  output point_y, input ready);
  modport sink   (input valid, input func, input position, input point_x,
                  input point_y, output ready);
endinterface

interface opl_rsp_if;
  import opl_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [31:0] read_x;
  logic signed [31:0] read_y;
  logic [1:0]         status;
  logic [CNT_W-1:0]   count;

  modport source (output valid, output read_x, output read_y, output status,
                  output count, input ready);
  modport sink   (input valid, input read_x, input read_y, input status,
                  input count, output ready);
endinterface

// ----- rtl/core/ordered_point_list.sv -----
// Ordered list of up to DEPTH points (x, y) held in a row of cells.
// Requests arrive on req_i (func, position, point_x, point_y); one result per
// request leaves on rsp_o (read_x, read_y, status, count).
// Append and insert place a point, shifting later entries up; remove drops
// an entry, shifting later entries down; read returns the entry at a
// position; clear empties the list. A full list refuses growth (status 1);
// remove or read at or past the count reports status 2.
// Every cell updates in the same cycle, so the result is valid the cycle
// after the request is accepted, and a new request may be accepted every
// cycle while results are taken.
// The result sits in an output register; req_i.ready is high while that
// register is empty or being drained, so a stalled receiver holds the
// result and stops requests until it is taken.
// Reset empties the list and the output register; the point entries
// themselves keep no reset value and are only read once written.
module ordered_point_list (
  input  logic clk_i,
  input  logic rst_ni,
  opl_req_if.sink   req_i,
  opl_rsp_if.source rsp_o
);
  import opl_pkg::*;

  logic             acc;
  logic             full;
  logic             in_range;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_d;
  cell_ctrl_t       ctrl;
  point_t           cell_data [DEPTH];
  point_t           rd_pt;
  status_e          st;

  logic               rsp_valid_q;
  logic signed [31:0] rsp_x_q;
  logic signed [31:0] rsp_y_q;
  logic [1:0]         rsp_st_q;
  logic [CNT_W-1:0]   rsp_cnt_q;

  // Accept while the output register is free or being drained
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign acc         = req_i.valid && req_i.ready;

  assign full     = (cnt_q == CNT_W'(DEPTH));
  assign in_range = (CMP_W'(req_i.position) < CMP_W'(cnt_q));

  // Decode the request into a cell command and the result
  always_comb begin
    ctrl.ins   = 1'b0;
    ctrl.rem   = 1'b0;
    ctrl.where = cnt_q[IDX_W-1:0];
    ctrl.pt.x  = req_i.point_x;
    ctrl.pt.y  = req_i.point_y;
    cnt_d      = cnt_q;
    st         = ST_DONE;
    rd_pt      = '0;
    case (req_i.func)
      FUNC_APPEND, FUNC_INSERT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          ctrl.ins = acc;
          if (req_i.func == FUNC_INSERT && in_range) begin
            ctrl.where = req_i.position[IDX_W-1:0];
          end
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      FUNC_REMOVE: begin
        if (in_range) begin
          ctrl.rem   = acc;
          ctrl.where = req_i.position[IDX_W-1:0];
          cnt_d      = cnt_q - CNT_W'(1);
        end else begin
          st = ST_RANGE;
        end
      end
      FUNC_READ: begin
        if (in_range) begin
          rd_pt = cell_data[req_i.position[IDX_W-1:0]];
        end else begin
          st = ST_RANGE;
        end
      end
      FUNC_CLEAR: begin
        cnt_d = '0;
      end
      default: begin
      end
    endcase
  end

  // Row of cells, each linked to its neighbors; the end cells see zero beyond the row
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    point_t left_pt;
    point_t right_pt;
    if (k == 0) begin : g_first
      assign left_pt = '0;
    end else begin : g_left
      assign left_pt = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_pt = '0;
    end else begin : g_right
      assign right_pt = cell_data[k+1];
    end
    opl_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (IDX_W'(k)),
      .left_i  (left_pt),
      .right_i (right_pt),
      .data_o  (cell_data[k])
    );
  end

  // Hold the count and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        cnt_q       <= cnt_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rsp_x_q   <= rd_pt.x;
      rsp_y_q   <= rd_pt.y;
      rsp_st_q  <= st;
      rsp_cnt_q <= cnt_d;
    end
  end

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.read_x = rsp_x_q;
  assign rsp_o.read_y = rsp_y_q;
  assign rsp_o.status = rsp_st_q;
  assign rsp_o.count  = rsp_cnt_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_acc_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> rsp_valid_q)
    else $error("accepted item gave no result");

  a_full_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_st_q == ST_FULL |-> rsp_cnt_q == CNT_W'(DEPTH))
    else $error("full status with room left");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_st_q != ST_DONE |-> rsp_x_q == 0 && rsp_y_q == 0)
    else $error("refused item carries point data");

  a_cnt_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> rsp_cnt_q == cnt_q)
    else $error("result count differs from list count");
`endif

endmodule

// ----- rtl/core/opl_cell.sv -----
module opl_cell (
  input  logic                       clk_i,
  input  opl_pkg::cell_ctrl_t        ctrl_i,
  input  logic [opl_pkg::IDX_W-1:0]  idx_i,
  input  opl_pkg::point_t            left_i,
  input  opl_pkg::point_t            right_i,
  output opl_pkg::point_t            data_o
);
  import opl_pkg::*;

  point_t data_q;
  point_t data_d;

  // Pick the new entry: own point, neighbor on shift, or hold
  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (idx_i == ctrl_i.where) begin
        data_d = ctrl_i.pt;
      end else if (idx_i > ctrl_i.where) begin
        data_d = left_i;
      end
    end else if (ctrl_i.rem) begin
      if (idx_i >= ctrl_i.where) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- tb/ordered_point_list_tb.sv -----
module ordered_point_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import opl_pkg::*;

  // Spare operation codes the block must ignore
  localparam logic [2:0] FUNC_SPARE_A = 3'd5;
  localparam logic [2:0] FUNC_SPARE_B = 3'd6;
  localparam logic [2:0] FUNC_SPARE_C = 3'd7;

  localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  localparam logic [POS_W-1:0]   POS_LAST  = '1;

  localparam int RANDOM_ITEMS = 1300;
  localparam int SEGMENT_LEN  = 40;
  localparam int QUIET_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic signed [31:0] read_x;
    logic signed [31:0] read_y;
    status_e            status;
    logic [CNT_W-1:0]   count;
  } list_result_t;

  // Shadow copy of the point list and the results it predicts
  class point_list_scoreboard;
    point_t       points[DEPTH];
    int           entries;
    list_result_t pending_results[$];
    int           mismatches;

    function new();
      entries    = 0;
      mismatches = 0;
    endfunction

    // Apply one accepted request to the shadow list and queue its result
    function void note_request(logic [2:0] op, logic [POS_W-1:0] pos,
                               logic signed [31:0] x, logic signed [31:0] y);
      list_result_t r;
      int           where;
      r = '{read_x: '0, read_y: '0, status: ST_DONE, count: '0};
      case (op)
        FUNC_APPEND, FUNC_INSERT: begin
          if (entries >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            where = (op == FUNC_INSERT && pos < entries) ? int'(pos) : entries;
            for (int k = entries; k > where; k--) points[k] = points[k-1];
            points[where] = '{x: x, y: y};
            entries++;
          end
        end
        FUNC_REMOVE: begin
          if (pos < entries) begin
            for (int k = pos; k + 1 < entries; k++) points[k] = points[k+1];
            entries--;
          end else begin
            r.status = ST_RANGE;
          end
        end
        FUNC_READ: begin
          if (pos < entries) begin
            r.read_x = points[pos].x;
            r.read_y = points[pos].y;
          end else begin
            r.status = ST_RANGE;
          end
        end
        FUNC_CLEAR: begin
          entries = 0;
        end
        default: begin
        end
      endcase
      r.count = CNT_W'(entries);
      pending_results.push_back(r);
    endfunction

    function void report(string field, longint want, longint got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    endfunction

    // Compare one delivered result with the oldest prediction
    function void check_result(list_result_t got);
      list_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: status %0d count %0d", got.status, got.count);
        return;
      end
      want = pending_results.pop_front();
      if (got.read_x !== want.read_x) report("read_x", want.read_x, got.read_x);
      if (got.read_y !== want.read_y) report("read_y", want.read_y, got.read_y);
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.count !== want.count)   report("count", want.count, got.count);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   calm;
  int   quiet_cycles;

  opl_req_if req_if();
  opl_rsp_if rsp_if();

  point_list_scoreboard sb = new();

  ordered_point_list u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watch both channels: check results first, then note new requests
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready)
        sb.check_result('{read_x: rsp_if.read_x, read_y: rsp_if.read_y,
                          status: status_e'(rsp_if.status), count: rsp_if.count});
      if (req_if.valid && req_if.ready)
        sb.note_request(req_if.func, req_if.position, req_if.point_x, req_if.point_y);
      if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Abort when nothing moves for too long
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  // Take results, stalling a random number of cycles before each one
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  // Offer one request after a random gap and hold it until accepted
  task automatic push_request(input logic [2:0] op, input logic [POS_W-1:0] pos,
                              input logic signed [31:0] x,
                              input logic signed [31:0] y);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.func     <= op;
    req_if.position <= pos;
    req_if.point_x  <= x;
    req_if.point_y  <= y;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  function automatic logic signed [31:0] draw_coord();
    logic signed [31:0] extremes[4];
    extremes = '{COORD_MAX, COORD_MIN, 32'sd0, -32'sd1};
    if ($urandom_range(0, 99) < 15) return extremes[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  initial begin
    int               mood;
    int               pick;
    int               cnt;
    logic [2:0]       op;
    logic [POS_W-1:0] pos;

    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.func     <= FUNC_APPEND;
    req_if.position <= '0;
    req_if.point_x  <= '0;
    req_if.point_y  <= '0;
    calm = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list, coordinate extremes, insert forms, spare codes, clear
    push_request(FUNC_READ,   '0,       '0,        '0);
    push_request(FUNC_REMOVE, POS_LAST, '0,        '0);
    push_request(FUNC_APPEND, '0,       COORD_MAX, COORD_MIN);
    push_request(FUNC_INSERT, '0,       COORD_MIN, COORD_MAX);
    push_request(FUNC_INSERT, POS_LAST, 32'sd0,    -32'sd1);
    push_request(FUNC_INSERT, 8'd1,     draw_coord(), draw_coord());
    push_request(FUNC_READ,   '0,       '0,        '0);
    push_request(FUNC_READ,   8'd3,     '0,        '0);
    push_request(FUNC_READ,   8'd4,     '0,        '0);
    push_request(FUNC_REMOVE, 8'd1,     '0,        '0);
    push_request(FUNC_REMOVE, 8'd3,     '0,        '0);
    push_request(FUNC_SPARE_A, 8'd0,    COORD_MAX, COORD_MAX);
    push_request(FUNC_SPARE_B, POS_LAST, COORD_MIN, COORD_MIN);
    push_request(FUNC_SPARE_C, 8'd2,    '0,        '0);
    push_request(FUNC_READ,   8'd2,     '0,        '0);
    push_request(FUNC_CLEAR,  POS_LAST, COORD_MAX, COORD_MIN);
    push_request(FUNC_READ,   '0,       '0,        '0);

    // Random: segments that lean toward growing, shrinking or neither
    mood = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT_LEN == 0) begin
        mood = (n == 0) ? 0 : $urandom_range(0, 2);
        calm = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      case (mood)
        0:       op = (pick < 30) ? FUNC_APPEND : (pick < 65) ? FUNC_INSERT :
                      (pick < 75) ? FUNC_REMOVE : FUNC_READ;
        1:       op = (pick < 15) ? FUNC_APPEND : (pick < 30) ? FUNC_INSERT :
                      (pick < 70) ? FUNC_REMOVE : FUNC_READ;
        default: op = (pick < 22) ? FUNC_APPEND : (pick < 45) ? FUNC_INSERT :
                      (pick < 65) ? FUNC_REMOVE : FUNC_READ;
      endcase
      if (pick == 95) op = FUNC_CLEAR;
      if (pick == 96) op = FUNC_SPARE_A;
      if (pick == 97) op = FUNC_SPARE_B;
      if (pick == 98) op = FUNC_SPARE_C;

      // Mostly valid positions, some at the count, some anywhere
      cnt  = sb.entries;
      pick = $urandom_range(0, 99);
      if (pick < 75)
        pos = POS_W'($urandom_range(0, (cnt > 0) ? cnt - 1 : 0));
      else if (pick < 85)
        pos = POS_W'(cnt);
      else if (pick < 90)
        pos = POS_LAST;
      else
        pos = POS_W'($urandom_range(0, 255));

      push_request(op, pos, draw_coord(), draw_coord());
    end
    req_if.valid <= 1'b0;
    calm = 1'b0;

    // Drain outstanding results, then allow a few settling cycles
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
